// ===== sv/utn_pkg.sv =====
package utn_pkg;

  localparam int TRAIL_DEPTH = 32;
  localparam int TRAIL_AW    = (TRAIL_DEPTH > 1) ? $clog2(TRAIL_DEPTH) : 1;
  localparam int TRAIL_CW    = $clog2(TRAIL_DEPTH + 1);

  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  localparam int CFG_IW = 3;
  localparam logic [CFG_IW-1:0] CFG_FOLD     = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_STRIP    = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_COLLAPSE = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_TRIM     = 3'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_present;
    logic       run_end;
    logic       text_end;
    logic       trim_overflow;
  } out_item_t;

  typedef struct packed {
    logic fold_fullwidth;
    logic strip_controls;
    logic collapse_whitespace;
    logic trim_edges;
  } cfg_t;

  typedef enum logic {
    EV_CODE = 1'b0,
    EV_MARK = 1'b1
  } ev_kind_t;

  // one decoded code point (after fold/strip) or an end-of-item mark
  typedef struct packed {
    ev_kind_t        kind;
    logic            last;
    logic            eot;
    logic [1:0]      nb_m1;
    logic [3:0][7:0] bytes;
  } ev_t;

endpackage

// ===== sv/utn_ram.sv =====
module utn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/utn_fifo.sv =====
module utn_fifo import utn_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  ev_t  push_data,
  output logic full,
  input  logic pop,
  output ev_t  pop_data,
  output logic empty
);

  ev_t             mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wptr_r, wptr_nxt;
  logic [Q_AW-1:0] rptr_r, rptr_nxt;
  logic [Q_CW-1:0] cnt_r, cnt_nxt;

  assign full     = (cnt_r == Q_CW'(Q_DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_data = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = push ? wptr_r + Q_AW'(1) : wptr_r;
    rptr_nxt = pop ? rptr_r + Q_AW'(1) : rptr_r;
    cnt_nxt  = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + Q_CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - Q_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

// ===== sv/utn_front.sv =====
module utn_front import utn_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  cfg_t     cfg,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  output logic     q_push,
  output ev_t      q_data,
  input  logic     q_full
);

  localparam logic [20:0] FW_LO      = 21'h0FF01;
  localparam logic [20:0] FW_HI      = 21'h0FF5E;
  localparam logic [20:0] FW_OFS     = 21'h0FEE0;
  localparam logic [20:0] IDEO_SPACE = 21'h03000;
  localparam logic [20:0] CP_SPACE   = 21'h00020;
  localparam logic [20:0] CP_TAB     = 21'h00009;
  localparam logic [20:0] CP_LF      = 21'h0000A;
  localparam logic [20:0] CP_CR      = 21'h0000D;
  localparam logic [20:0] CP_DEL     = 21'h0007F;
  localparam logic [20:0] C1_LO      = 21'h00080;
  localparam logic [20:0] C1_HI      = 21'h0009F;

  typedef enum logic [3:0] {
    F_IDLE = 4'b0001,
    F_BYTE = 4'b0010,
    F_REL  = 4'b0100,
    F_MARK = 4'b1000
  } fst_t;

  fst_t            st_r, st_nxt;
  logic [7:0]      byte_r, byte_nxt;
  logic            eot_r, eot_nxt;
  logic            bpend_r, bpend_nxt;
  logic            pushed_r, pushed_nxt;
  logic [2:0][7:0] held_r, held_nxt;
  logic [1:0]      hcnt_r, hcnt_nxt;
  logic [2:0]      exp_r, exp_nxt;
  logic [20:0]     part_r, part_nxt;
  logic [1:0]      ridx_r, ridx_nxt;

  logic        is_cont, lead2, lead3, lead4, lead, complete, single;
  logic [20:0] part_new, cp, v;
  logic [7:0]  sbyte;
  logic        fw_hit, sp_hit, drop, code_now, push_now;
  ev_t         ev;

  always_comb begin
    is_cont  = (byte_r[7:6] == 2'b10);
    lead2    = byte_r inside {[8'hC2:8'hDF]};
    lead3    = byte_r inside {[8'hE0:8'hEF]};
    lead4    = byte_r inside {[8'hF0:8'hF4]};
    lead     = lead2 || lead3 || lead4;
    part_new = {part_r[14:0], byte_r[5:0]};
    complete = (({1'b0, hcnt_r} + 3'd1) >= exp_r) || (hcnt_r == 2'd3);
    single   = (st_r == F_REL) || (hcnt_r == 2'd0);
    sbyte    = (st_r == F_REL) ? held_r[ridx_r] : byte_r;
    cp       = single ? {13'b0, sbyte} : part_new;

    fw_hit = cfg.fold_fullwidth && (cp inside {[FW_LO:FW_HI]});
    sp_hit = cfg.fold_fullwidth && (cp == IDEO_SPACE);
    if (fw_hit) begin
      v = cp - FW_OFS;
    end else if (sp_hit) begin
      v = CP_SPACE;
    end else begin
      v = cp;
    end
    drop = cfg.strip_controls &&
           (((v < CP_SPACE) && (v != CP_TAB) && (v != CP_LF) && (v != CP_CR)) ||
            (v == CP_DEL) || (v inside {[C1_LO:C1_HI]}));

    ev.kind = EV_CODE;
    ev.last = 1'b0;
    ev.eot  = eot_r;
    if (fw_hit || sp_hit) begin
      ev.nb_m1 = 2'd0;
      ev.bytes = {24'b0, v[7:0]};
    end else if (single) begin
      ev.nb_m1 = 2'd0;
      ev.bytes = {24'b0, sbyte};
    end else begin
      ev.nb_m1    = hcnt_r;
      ev.bytes[0] = held_r[0];
      ev.bytes[1] = (hcnt_r > 2'd1) ? held_r[1] : byte_r;
      ev.bytes[2] = (hcnt_r > 2'd2) ? held_r[2] : byte_r;
      ev.bytes[3] = byte_r;
    end
  end

  always_comb begin
    st_nxt     = st_r;
    byte_nxt   = byte_r;
    eot_nxt    = eot_r;
    bpend_nxt  = bpend_r;
    pushed_nxt = pushed_r;
    held_nxt   = held_r;
    hcnt_nxt   = hcnt_r;
    exp_nxt    = exp_r;
    part_nxt   = part_r;
    ridx_nxt   = ridx_r;
    q_push     = 1'b0;
    q_data     = ev;
    in_ready   = (st_r == F_IDLE);
    code_now   = (hcnt_r == 2'd0) ? !lead : complete;
    push_now   = 1'b0;

    case (st_r)
      F_IDLE: begin
        if (in_valid) begin
          byte_nxt   = in_data.data_byte;
          eot_nxt    = in_data.end_of_text;
          bpend_nxt  = in_data.byte_valid;
          pushed_nxt = 1'b0;
          ridx_nxt   = 2'd0;
          if (in_data.byte_valid) begin
            st_nxt = F_BYTE;
          end else if (in_data.end_of_text) begin
            st_nxt = (hcnt_r != 2'd0) ? F_REL : F_MARK;
          end
        end
      end
      F_BYTE: begin
        if ((hcnt_r != 2'd0) && !is_cont) begin
          st_nxt   = F_REL;
          ridx_nxt = 2'd0;
        end else if (!code_now || drop || !q_full) begin
          if ((hcnt_r == 2'd0) && lead) begin
            held_nxt[0] = byte_r;
            hcnt_nxt    = 2'd1;
            if (lead2) begin
              exp_nxt  = 3'd2;
              part_nxt = {16'b0, byte_r[4:0]};
            end else if (lead3) begin
              exp_nxt  = 3'd3;
              part_nxt = {17'b0, byte_r[3:0]};
            end else begin
              exp_nxt  = 3'd4;
              part_nxt = {18'b0, byte_r[2:0]};
            end
          end else if ((hcnt_r != 2'd0) && !complete) begin
            held_nxt[hcnt_r] = byte_r;
            hcnt_nxt         = hcnt_r + 2'd1;
            part_nxt         = part_new;
          end else if (hcnt_r != 2'd0) begin
            hcnt_nxt = 2'd0;
            exp_nxt  = 3'd0;
            part_nxt = 21'd0;
          end
          push_now    = code_now && !drop;
          q_push      = push_now;
          q_data.last = !eot_r;
          pushed_nxt  = pushed_r || push_now;
          bpend_nxt   = 1'b0;
          ridx_nxt    = 2'd0;
          if (eot_r) begin
            st_nxt = (hcnt_nxt != 2'd0) ? F_REL : F_MARK;
          end else if (push_now) begin
            st_nxt = F_IDLE;
          end else if (pushed_r) begin
            st_nxt = F_MARK;
          end else begin
            st_nxt = F_IDLE;
          end
        end
      end
      F_REL: begin
        if (drop || !q_full) begin
          q_push     = !drop;
          pushed_nxt = pushed_r || !drop;
          if (ridx_r == hcnt_r - 2'd1) begin
            hcnt_nxt = 2'd0;
            exp_nxt  = 3'd0;
            part_nxt = 21'd0;
            st_nxt   = bpend_r ? F_BYTE : F_MARK;
          end else begin
            ridx_nxt = ridx_r + 2'd1;
          end
        end
      end
      F_MARK: begin
        if (!q_full) begin
          q_push      = 1'b1;
          q_data.kind = EV_MARK;
          q_data.last = 1'b1;
          st_nxt      = F_IDLE;
        end
      end
      default: st_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    held_r <= held_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= F_IDLE;
      eot_r    <= 1'b0;
      bpend_r  <= 1'b0;
      pushed_r <= 1'b0;
      hcnt_r   <= 2'd0;
      exp_r    <= 3'd0;
      part_r   <= 21'd0;
      ridx_r   <= 2'd0;
    end else begin
      st_r     <= st_nxt;
      eot_r    <= eot_nxt;
      bpend_r  <= bpend_nxt;
      pushed_r <= pushed_nxt;
      hcnt_r   <= hcnt_nxt;
      exp_r    <= exp_nxt;
      part_r   <= part_nxt;
      ridx_r   <= ridx_nxt;
    end
  end

endmodule

// ===== sv/utn_back.sv =====
module utn_back import utn_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      q_empty,
  output logic      q_pop,
  input  ev_t       q_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam logic [7:0] ASCII_SPACE = 8'h20;

  typedef enum logic [3:0] {
    B_IDLE  = 4'b0001,
    B_CODE  = 4'b0010,
    B_MARK  = 4'b0100,
    B_FLUSH = 4'b1000
  } bst_t;

  function automatic logic is_ws(input logic [7:0] b);
    return (b == ASCII_SPACE) || (b inside {[8'h09:8'h0D]});
  endfunction

  bst_t                st_r, st_nxt;
  ev_t                 ev_r, ev_nxt;
  logic [1:0]          idx_r, idx_nxt;
  logic                isr_r, isr_nxt;
  logic                anye_r, anye_nxt;
  logic [TRAIL_CW-1:0] cnt_r, cnt_nxt;
  logic                ovf_r, ovf_nxt;
  logic [TRAIL_AW-1:0] fl_idx_r, fl_idx_nxt;
  logic                fl_mark_r, fl_mark_nxt;
  logic                pend_v_r, pend_v_nxt;
  out_item_t           pend_r, pend_nxt;
  logic                out_v_r, out_v_nxt;
  out_item_t           out_r, out_nxt;

  logic                ram_we, ram_re;
  logic [TRAIL_AW-1:0] ram_raddr;
  logic [7:0]          ram_rdata;

  logic [7:0] cur_b, cur_x, put_byte;
  logic       b_ws, x_ws, sp, need_fl, buf_path, sink_ok, out_free;
  logic       put, ld, adv, fl_start;

  utn_ram #(
    .WIDTH (8),
    .DEPTH (TRAIL_DEPTH)
  ) u_trail (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt_r[TRAIL_AW-1:0]),
    .wdata (cur_x),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    cur_b    = ev_r.bytes[idx_r];
    b_ws     = is_ws(cur_b);
    sp       = cfg.collapse_whitespace && isr_r && anye_r;
    cur_x    = sp ? ASCII_SPACE : cur_b;
    x_ws     = is_ws(cur_x);
    need_fl  = (cnt_r != '0) && (!x_ws || !cfg.trim_edges);
    buf_path = x_ws && cfg.trim_edges;
    sink_ok  = !pend_v_r || !out_v_r || out_ready;
    out_free = !out_v_r || out_ready;
  end

  always_comb begin
    st_nxt      = st_r;
    ev_nxt      = ev_r;
    idx_nxt     = idx_r;
    isr_nxt     = isr_r;
    anye_nxt    = anye_r;
    cnt_nxt     = cnt_r;
    ovf_nxt     = ovf_r;
    fl_idx_nxt  = fl_idx_r;
    fl_mark_nxt = fl_mark_r;
    pend_v_nxt  = pend_v_r;
    pend_nxt    = pend_r;
    out_v_nxt   = out_v_r;
    out_nxt     = out_r;
    q_pop       = 1'b0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_raddr   = '0;
    put         = 1'b0;
    put_byte    = cur_x;
    ld          = 1'b0;
    adv         = 1'b0;
    fl_start    = 1'b0;

    if (out_v_r && out_ready) begin
      out_v_nxt = 1'b0;
    end

    case (st_r)
      B_IDLE: ld = 1'b1;
      B_CODE: begin
        if (cfg.collapse_whitespace && b_ws) begin
          isr_nxt = 1'b1;
          adv     = 1'b1;
        end else if (need_fl) begin
          fl_start    = 1'b1;
          fl_mark_nxt = 1'b0;
        end else if (buf_path) begin
          if (anye_r) begin
            if (cnt_r < TRAIL_CW'(TRAIL_DEPTH)) begin
              ram_we  = 1'b1;
              cnt_nxt = cnt_r + TRAIL_CW'(1);
            end else begin
              ovf_nxt = 1'b1;
            end
          end
          isr_nxt = 1'b0;
          adv     = !sp;
        end else if (sink_ok) begin
          put     = 1'b1;
          isr_nxt = 1'b0;
          adv     = !sp;
          if (!x_ws) begin
            anye_nxt = 1'b1;
          end
        end
      end
      B_MARK: begin
        if (ev_r.eot && !cfg.trim_edges && (cnt_r != '0)) begin
          fl_start    = 1'b1;
          fl_mark_nxt = 1'b1;
        end else if (out_free || (!pend_v_r && !ev_r.eot)) begin
          if (pend_v_r) begin
            out_nxt          = pend_r;
            out_nxt.run_end  = 1'b1;
            out_nxt.text_end = ev_r.eot;
            if (ev_r.eot) begin
              out_nxt.trim_overflow = ovf_r;
            end
            out_v_nxt  = 1'b1;
            pend_v_nxt = 1'b0;
          end else if (ev_r.eot) begin
            out_nxt   = '{out_byte: 8'h00, byte_present: 1'b0, run_end: 1'b1,
                          text_end: 1'b1, trim_overflow: ovf_r};
            out_v_nxt = 1'b1;
          end
          if (ev_r.eot) begin
            isr_nxt  = 1'b0;
            anye_nxt = 1'b0;
            cnt_nxt  = '0;
            ovf_nxt  = 1'b0;
          end
          ld = 1'b1;
        end
      end
      B_FLUSH: begin
        put_byte = ram_rdata;
        if (sink_ok) begin
          put = 1'b1;
          if ((TRAIL_CW'(fl_idx_r) + TRAIL_CW'(1)) == cnt_r) begin
            cnt_nxt = '0;
            st_nxt  = fl_mark_r ? B_MARK : B_CODE;
          end else begin
            ram_re     = 1'b1;
            ram_raddr  = fl_idx_r + TRAIL_AW'(1);
            fl_idx_nxt = fl_idx_r + TRAIL_AW'(1);
          end
        end
      end
      default: st_nxt = B_IDLE;
    endcase

    if (adv) begin
      if (idx_r == ev_r.nb_m1) begin
        if (ev_r.last) begin
          st_nxt = B_MARK;
        end else begin
          ld = 1'b1;
        end
      end else begin
        idx_nxt = idx_r + 2'd1;
      end
    end

    if (fl_start) begin
      ram_re     = 1'b1;
      ram_raddr  = '0;
      fl_idx_nxt = '0;
      st_nxt     = B_FLUSH;
    end

    if (put) begin
      pend_nxt   = '{out_byte: put_byte, byte_present: 1'b1, run_end: 1'b0,
                     text_end: 1'b0, trim_overflow: ovf_r};
      pend_v_nxt = 1'b1;
      if (pend_v_r) begin
        out_nxt   = pend_r;
        out_v_nxt = 1'b1;
      end
    end

    if (ld) begin
      if (!q_empty) begin
        q_pop   = 1'b1;
        ev_nxt  = q_data;
        idx_nxt = 2'd0;
        st_nxt  = (q_data.kind == EV_CODE) ? B_CODE : B_MARK;
      end else begin
        st_nxt = B_IDLE;
      end
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    ev_r   <= ev_nxt;
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= B_IDLE;
      idx_r     <= 2'd0;
      isr_r     <= 1'b0;
      anye_r    <= 1'b0;
      cnt_r     <= '0;
      ovf_r     <= 1'b0;
      fl_idx_r  <= '0;
      fl_mark_r <= 1'b0;
      pend_v_r  <= 1'b0;
      out_v_r   <= 1'b0;
    end else begin
      st_r      <= st_nxt;
      idx_r     <= idx_nxt;
      isr_r     <= isr_nxt;
      anye_r    <= anye_nxt;
      cnt_r     <= cnt_nxt;
      ovf_r     <= ovf_nxt;
      fl_idx_r  <= fl_idx_nxt;
      fl_mark_r <= fl_mark_nxt;
      pend_v_r  <= pend_v_nxt;
      out_v_r   <= out_v_nxt;
    end
  end

endmodule

// ===== sv/utf8_text_normalizer_core.sv =====
// Channel  Ports                         Payload              Transfer when
// input    in_valid / in_ready           in_data (in_item_t)  in_valid && in_ready
// output   out_valid / out_ready         out_data (out_item_t) out_valid && out_ready
// config   cfg_valid / cfg_ready         cfg_index, cfg_data  cfg_valid && cfg_ready
//
// Front: accepts an item, then passes over its byte (a byte that breaks a held
// sequence first has the held bytes released one at a time, then is passed over
// again), and sends an end mark (end of text, or a release the byte does not close).
// Back: handles each code point byte or inserted space in turn, closes each item,
// and flushes buffered trailing spaces; one result is held back for run_end. A 2-entry queue
// lets each side stall alone. Sync active-low reset, no clearing pass.
module utf8_text_normalizer_core import utn_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic              cfg_data
);

  cfg_t cfg_r;
  logic q_push, q_full, q_pop, q_empty;
  ev_t  q_wdata, q_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_FOLD:     cfg_r.fold_fullwidth      <= cfg_data;
        CFG_STRIP:    cfg_r.strip_controls      <= cfg_data;
        CFG_COLLAPSE: cfg_r.collapse_whitespace <= cfg_data;
        CFG_TRIM:     cfg_r.trim_edges          <= cfg_data;
        default: ;
      endcase
    end
  end

  utn_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_push   (q_push),
    .q_data   (q_wdata),
    .q_full   (q_full)
  );

  utn_fifo u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  utn_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .q_data    (q_rdata),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
